/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// When the trigger holds, the consequence holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg)
`endif

`endif

/* rtl/tfpa_pkg.sv */
// ----------------------------------------------------------------------------
// tfpa_pkg
// Types and constants shared by the TLV frame parser and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tfpa_pkg;

  // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from address bit 2.
  localparam logic REG_TRADE     = 1'b0;
  localparam logic REG_HEARTBEAT = 1'b1;

  // Register reset values.
  localparam logic [7:0] TRADE_RESET     = 8'd1;
  localparam logic [7:0] HEARTBEAT_RESET = 8'd2;

  // Frame layout.
  localparam logic [15:0] HDR_BYTES     = 16'd3;
  localparam logic [15:0] FULL_FRAME    = 16'd11;
  localparam logic [15:0] PAYLOAD_BYTES = 16'd8;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_LEN_LO  = 4'b0001,
    PH_LEN_HI  = 4'b0010,
    PH_TYPE    = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  // Type codes handed from the register block to the parser.
  typedef struct packed {
    logic [7:0] trade_code;
    logic [7:0] heartbeat_code;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/tlv_frame_parse_accumulate_core.sv */
// ----------------------------------------------------------------------------
// tlv_frame_parse_accumulate_core
// Parses length-prefixed TLV frames a byte at a time and sums trade and
// heartbeat contributions, giving the total on the last byte of each buffer.
//
//   Channel   Direction  Handshake             Word
//   input     in         in_valid/in_ready     data_byte, last_byte
//   output    out        out_valid/out_ready   total (one per buffer)
//   config    in         psel/penable/pwrite   paddr, pwdata, prdata
//
// One byte is accepted every cycle while no last byte waits on a stalled result;
// a byte passes through the input register, then its total goes to the result register.
// The critical path is the frame completion add into the 64-bit running sum.
// A stalled result only holds back a following last byte; other bytes flow on.
// Reset is synchronous and restores type codes 1 and 2 and an empty parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_frame_parse_accumulate_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tfpa_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tfpa_pkg::DATA_W-1:0]  pwdata,
  output logic      [tfpa_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         last_byte,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  output logic [63:0]                       total,
  output logic                              out_valid,
  input  wire logic                         out_ready
);

  tfpa_pkg::cfg_t cfg;
  logic           in_q_valid;
  logic [7:0]     in_q_byte;
  logic           in_q_last;
  logic           item_take;

  // Configuration registers.
  tfpa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: refills whenever its byte moves on to the parser.
  assign in_ready = !in_q_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= data_byte;
      in_q_last <= last_byte;
    end
  end

  // Frame parser and result register.
  tfpa_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_q_valid),
    .item_byte  (in_q_byte),
    .item_last  (in_q_last),
    .item_take  (item_take),
    .total      (total),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

`default_nettype wire

/* rtl/tfpa_regs.sv */
// ----------------------------------------------------------------------------
// tfpa_regs
// APB-style configuration registers holding the trade and heartbeat type codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpa_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tfpa_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tfpa_pkg::DATA_W-1:0]  pwdata,
  output logic      [tfpa_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output tfpa_pkg::cfg_t                    cfg
);

  logic wr_en;
  logic reg_sel;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trade_code     <= tfpa_pkg::TRADE_RESET;
      cfg.heartbeat_code <= tfpa_pkg::HEARTBEAT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        tfpa_pkg::REG_TRADE:     cfg.trade_code     <= pwdata[7:0];
        tfpa_pkg::REG_HEARTBEAT: cfg.heartbeat_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      tfpa_pkg::REG_TRADE:     prdata = {24'd0, cfg.trade_code};
      tfpa_pkg::REG_HEARTBEAT: prdata = {24'd0, cfg.heartbeat_code};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/tfpa_parser.sv */
// ----------------------------------------------------------------------------
// tfpa_parser
// Frame parser state, running sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tfpa_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tfpa_pkg::cfg_t cfg,
  input  wire logic           item_valid,
  input  wire logic [7:0]     item_byte,
  input  wire logic           item_last,
  output logic                item_take,
  output logic [63:0]         total,
  output logic                out_valid,
  input  wire logic           out_ready
);

  tfpa_pkg::phase_t phase, phase_next;
  logic [15:0] frame_pos, frame_pos_next;
  logic [15:0] frame_len, frame_len_next;
  logic [7:0]  frame_kind, frame_kind_next;
  logic [63:0] payload_word, payload_word_next;
  logic [63:0] running_sum, running_sum_next;
  logic        halted, halted_next;

  logic        finish;
  logic [15:0] pay_idx;
  logic [15:0] pos_inc;
  logic [31:0] trade_sum;
  logic [63:0] contrib;

  // A byte is taken unless it is the last one and the result slot is still full.
  assign item_take = item_valid && (!item_last || !out_valid || out_ready);

  assign pay_idx   = frame_pos - tfpa_pkg::HDR_BYTES;
  assign pos_inc   = frame_pos + 16'd1;
  assign trade_sum = payload_word_next[31:0] + payload_word_next[63:32];

  // Next-state logic for one byte.
  always_comb begin
    phase_next        = phase;
    frame_pos_next    = frame_pos;
    frame_len_next    = frame_len;
    frame_kind_next   = frame_kind;
    payload_word_next = payload_word;
    halted_next       = halted;
    finish            = 1'b0;

    if (item_take && !halted) begin
      unique case (phase)
        tfpa_pkg::PH_LEN_LO: begin
          frame_len_next = {8'd0, item_byte};
          frame_pos_next = 16'd1;
          phase_next     = tfpa_pkg::PH_LEN_HI;
        end
        tfpa_pkg::PH_LEN_HI: begin
          frame_len_next = {item_byte, frame_len[7:0]};
          frame_pos_next = 16'd2;
          if (frame_len_next < tfpa_pkg::HDR_BYTES) begin
            halted_next = 1'b1;
          end else begin
            phase_next = tfpa_pkg::PH_TYPE;
          end
        end
        tfpa_pkg::PH_TYPE: begin
          frame_kind_next   = item_byte;
          frame_pos_next    = tfpa_pkg::HDR_BYTES;
          payload_word_next = '0;
          if (frame_len == tfpa_pkg::HDR_BYTES) begin
            finish = 1'b1;
          end else begin
            phase_next = tfpa_pkg::PH_PAYLOAD;
          end
        end
        tfpa_pkg::PH_PAYLOAD: begin
          // Only the first eight payload bytes are kept.
          for (int i = 0; i < 8; i++) begin
            if (pay_idx < tfpa_pkg::PAYLOAD_BYTES && pay_idx[2:0] == 3'(i)) begin
              payload_word_next[8*i +: 8] = item_byte;
            end
          end
          frame_pos_next = pos_inc;
          if (pos_inc == frame_len) begin
            finish = 1'b1;
          end
        end
        default: ;
      endcase

      if (finish) begin
        phase_next     = tfpa_pkg::PH_LEN_LO;
        frame_pos_next = '0;
      end
    end
  end

  // Contribution of a completed frame; a trade wins when both codes match.
  always_comb begin
    contrib = '0;
    if (finish && frame_len >= tfpa_pkg::FULL_FRAME) begin
      if (frame_kind_next == cfg.trade_code) begin
        contrib = {32'd0, trade_sum};
      end else if (frame_kind_next == cfg.heartbeat_code) begin
        contrib = payload_word_next;
      end
    end
  end

  assign running_sum_next = running_sum + contrib;

  // Parser state; the last byte of a buffer clears everything.
  always_ff @(posedge clk) begin
    if (rst || (item_take && item_last)) begin
      phase        <= tfpa_pkg::PH_LEN_LO;
      frame_pos    <= '0;
      frame_len    <= '0;
      frame_kind   <= '0;
      payload_word <= '0;
      running_sum  <= '0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      frame_pos    <= frame_pos_next;
      frame_len    <= frame_len_next;
      frame_kind   <= frame_kind_next;
      payload_word <= payload_word_next;
      running_sum  <= running_sum_next;
      halted       <= halted_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take && item_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item_last) begin
      total <= running_sum_next;
    end
  end

  // Checks on the parser state.
  `ASSERT_NEXT(a_clear_after_last, clk, rst, item_take && item_last,
    running_sum == '0 && phase == tfpa_pkg::PH_LEN_LO && !halted,
    "state not cleared after last byte")
  `ASSERT_ALWAYS(a_halt_phase, clk, rst, !halted || phase == tfpa_pkg::PH_LEN_HI,
    "halted outside length high phase")
  `ASSERT_ALWAYS(a_payload_pos, clk, rst, phase != tfpa_pkg::PH_PAYLOAD ||
    (frame_pos >= tfpa_pkg::HDR_BYTES && frame_pos < frame_len),
    "payload position out of frame")

endmodule

`default_nettype wire
